/* rtl/rntm_pkg.sv */
package rntm_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned QueueDepth = 2;

  // 1000 in Q16.16; compared against |d| directly, i.e. |d| < 1000 * 2^16 (exact)
  localparam logic [31:0] ErrLimitRoot = 32'd65536000;

  typedef struct packed {
    logic        mode;
    logic [7:0]  entry_index;
    logic [31:0] entry_ratio;
    logic [31:0] entry_code;
    logic [15:0] high_echo_one;
    logic [15:0] high_echo_two;
    logic [15:0] low_echo_one;
    logic [15:0] low_echo_two;
    logic        end_of_image;
  } req_t;

  typedef struct packed {
    logic [31:0] adc_value;
    logic [7:0]  best_entry;
    logic        zero_denominator;
    logic        image_done;
  } rsp_t;

  // classified request passed from front to back
  typedef struct packed {
    logic        is_load;
    logic [7:0]  entry_index;
    logic [31:0] entry_ratio;
    logic [31:0] entry_code;
    logic [31:0] num;
    logic [31:0] den;
    logic        end_of_image;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SEARCH, ST_DRAIN, ST_FETCH, ST_OUT
  } state_e;

endpackage

/* rtl/rntm_front.sv */
module rntm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rntm_pkg::req_t req_i,
  input  logic           valid_i,
  output logic           ready_o,
  output rntm_pkg::job_t job_o,
  output logic           job_valid_o,
  input  logic           job_ready_i
);

  localparam int unsigned PtrW = $clog2(rntm_pkg::QueueDepth);

  rntm_pkg::job_t          mem_q [rntm_pkg::QueueDepth];
  logic [PtrW-1:0]         wr_q, rd_q;
  logic [PtrW:0]           cnt_q;
  rntm_pkg::job_t          job_d;
  logic                    push, pop;

  always_comb begin
    job_d.is_load      = ~req_i.mode;
    job_d.entry_index  = req_i.entry_index;
    job_d.entry_ratio  = req_i.entry_ratio;
    job_d.entry_code   = req_i.entry_code;
    job_d.num          = req_i.high_echo_two * req_i.low_echo_one;
    job_d.den          = req_i.high_echo_one * req_i.low_echo_two;
    job_d.end_of_image = req_i.end_of_image;
  end

  assign ready_o     = (cnt_q != (PtrW+1)'(rntm_pkg::QueueDepth));
  assign push        = valid_i & ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o & job_ready_i;
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

/* rtl/rntm_back.sv */
module rntm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rntm_pkg::CntW-1:0]  entries_i,
  input  rntm_pkg::job_t             job_i,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  output rntm_pkg::rsp_t             rsp_o,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i
);

  localparam int unsigned IdxW = rntm_pkg::IdxW;
  localparam int unsigned CntW = rntm_pkg::CntW;

  logic [31:0] ratio_mem [rntm_pkg::TableDepth];
  logic [31:0] code_mem  [rntm_pkg::TableDepth];

  rntm_pkg::state_e state_q, state_d;
  rntm_pkg::job_t   job_q;
  logic [48:0]      rem_q, rem_d;
  logic [47:0]      quo_q, quo_d;
  logic [5:0]       bit_q, bit_d;
  logic [CntW-1:0]  cnt_q, cnt_d, lim_q, lim_d;
  logic [IdxW-1:0]  best_q, best_d, rd_idx_q, rd_idx_d;
  logic [32:0]      bdiff_q, bdiff_d;
  logic             rvalid_q, rvalid_d;
  logic [31:0]      rdata_q, code_q;
  logic             zden_q, zden_d;
  rntm_pkg::rsp_t   rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [31:0]      meas;
  logic [32:0]      diff;
  logic [48:0]      trial;
  logic             rd_en, code_en;

  assign meas  = (quo_q[47:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
  assign diff  = (meas > rdata_q) ? {1'b0, meas - rdata_q} : {1'b0, rdata_q - meas};
  assign trial = {rem_q[47:0], quo_q[47]} - {17'd0, job_q.den};

  always_ff @(posedge clk_i) begin
    if (state_q == rntm_pkg::ST_IDLE && job_valid_i && job_i.is_load) begin
      ratio_mem[job_i.entry_index[IdxW-1:0]] <= job_i.entry_ratio;
      code_mem[job_i.entry_index[IdxW-1:0]]  <= job_i.entry_code;
    end
    if (rd_en)   rdata_q <= ratio_mem[rd_idx_q];
    if (code_en) code_q  <= code_mem[best_q];
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    best_d      = best_q;
    rd_idx_d    = rd_idx_q;
    bdiff_d     = bdiff_q;
    rvalid_d    = 1'b0;
    zden_d      = zden_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q & ~rsp_ready_i;
    job_ready_o = 1'b0;
    rd_en       = 1'b0;
    code_en     = 1'b0;
    unique case (state_q)
      rntm_pkg::ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i && !job_i.is_load) begin
          rem_d    = '0;
          quo_d    = {job_i.num, 16'd0};
          bit_d    = 6'd48;
          best_d   = '0;
          bdiff_d  = {1'b0, rntm_pkg::ErrLimitRoot};
          zden_d   = (job_i.den == '0);
          lim_d    = (entries_i > CntW'(rntm_pkg::TableDepth)) ?
                     CntW'(rntm_pkg::TableDepth) : entries_i;
          state_d  = (job_i.den == '0) ? rntm_pkg::ST_FETCH : rntm_pkg::ST_DIV;
        end
      end
      rntm_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!trial[48]) rem_d = trial;
        else            rem_d = {rem_q[47:0], quo_q[47]};
        quo_d   = {quo_q[46:0], ~trial[48]};
        bit_d   = bit_q - 6'd1;
        if (bit_q == 6'd1) begin
          cnt_d    = '0;
          rd_idx_d = '0;
          state_d  = rntm_pkg::ST_SEARCH;
        end
      end
      rntm_pkg::ST_SEARCH: begin
        if (rvalid_q && diff < bdiff_q) begin
          bdiff_d = diff;
          best_d  = rd_idx_q - 1'b1;
        end
        if (cnt_q == lim_q) state_d = rntm_pkg::ST_DRAIN;
        else begin
          rd_en    = 1'b1;
          rvalid_d = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      rntm_pkg::ST_DRAIN: begin
        state_d = rntm_pkg::ST_FETCH;
      end
      rntm_pkg::ST_FETCH: begin
        code_en = 1'b1;
        state_d = rntm_pkg::ST_OUT;
      end
      rntm_pkg::ST_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d.adc_value        = code_q;
          rsp_d.best_entry       = 8'(best_q);
          rsp_d.zero_denominator = zden_q;
          rsp_d.image_done       = job_q.end_of_image;
          rsp_valid_d            = 1'b1;
          state_d                = rntm_pkg::ST_IDLE;
        end
      end
      default: state_d = rntm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rntm_pkg::ST_IDLE && job_valid_i) job_q <= job_i;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    bdiff_q  <= bdiff_d;
    rsp_q    <= rsp_d;
    lim_q    <= lim_d;
    zden_q   <= zden_d;
    best_q   <= best_d;
    rd_idx_q <= rd_idx_d;
    cnt_q    <= cnt_d;
    bit_q    <= bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rntm_pkg::ST_IDLE;
      rvalid_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rvalid_q    <= rvalid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

/* rtl/ratio_nearest_table_match_unit.sv */
// Flow: a request passes through the input queue, then the divider, then a walk of
// the searched entries (entries_in_use, at most 256); a zero denominator skips both.
// Pixels are processed one at a time: the divider and the single-port table walk
// finish one pixel before the next starts; load requests are written from idle.
// Reset: asynchronous active low; clears control state, entries_in_use becomes 256,
// table contents stay undefined until loaded.
module ratio_nearest_table_match_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rntm_pkg::req_t req_i,
  input  logic           valid_i,
  output logic           ready_o,
  output rntm_pkg::rsp_t rsp_o,
  output logic           valid_o,
  input  logic           ready_i,
  input  logic           cfg_we_i,
  input  logic [8:0]     cfg_data_i
);

  logic [rntm_pkg::CntW-1:0] entries_q;
  rntm_pkg::job_t            job;
  logic                      job_valid, job_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) entries_q <= rntm_pkg::CntW'(256);
    else if (cfg_we_i) entries_q <= rntm_pkg::CntW'(cfg_data_i);
  end

  rntm_front u_front (
    .clk_i, .rst_ni, .req_i, .valid_i, .ready_o,
    .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  rntm_back u_back (
    .clk_i, .rst_ni, .entries_i(entries_q),
    .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready),
    .rsp_o, .rsp_valid_o(valid_o), .rsp_ready_i(ready_i)
  );

`ifndef SYNTHESIS
  a_zden_entry0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.zero_denominator |-> rsp_o.best_entry == '0)
    else $error("zero denominator must select entry 0");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(rsp_o))
    else $error("response changed while stalled");
`endif

endmodule
